@@ rtl/core/luhn_pkg.sv @@
`default_nettype none

package luhn_pkg;

   // Field widths of the channels.
   localparam int CARD_W  = 63;
   localparam int COUNT_W = 5;
   localparam int CLASS_W = 2;

   // Decimal conversion: the largest card number has nineteen digits.
   localparam int DIGITS         = 19;
   localparam int BCD_W          = 4 * DIGITS;
   localparam int BITS_PER_CYCLE = 4;
   localparam int BIN_W          = ((CARD_W + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE)
                                   * BITS_PER_CYCLE;
   localparam int CONV_STEPS     = BIN_W / BITS_PER_CYCLE;

   // Default depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Arithmetic constants of the check.
   localparam logic [4:0] DIGIT_BASE  = 5'd10;
   localparam logic [4:0] DOUBLE_FOLD = 5'd9;
   localparam logic [3:0] DOUBLE_MIN  = 4'd5;

   // Card classes.
   localparam logic [CLASS_W-1:0] CLASS_INVALID    = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_AMEX       = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_VISA       = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_MASTERCARD = 2'd3;

   // Lengths and leading digits of each class.
   localparam logic [COUNT_W-1:0] AMEX_LEN       = 5'd15;
   localparam logic [COUNT_W-1:0] VISA_LEN_SHORT = 5'd13;
   localparam logic [COUNT_W-1:0] VISA_LEN_LONG  = 5'd16;
   localparam logic [COUNT_W-1:0] MC_LEN         = 5'd16;
   localparam logic [3:0] AMEX_LEAD      = 4'd3;
   localparam logic [3:0] AMEX_NEXT_LO   = 4'd4;
   localparam logic [3:0] AMEX_NEXT_HI   = 4'd7;
   localparam logic [3:0] VISA_LEAD      = 4'd4;
   localparam logic [3:0] MC_LEAD        = 4'd5;
   localparam logic [3:0] MC_NEXT_MIN    = 4'd1;
   localparam logic [3:0] MC_NEXT_MAX    = 4'd5;

   // One queued card number, with its zero flag worked out on entry.
   typedef struct packed {
      logic [CARD_W-1:0] card_number;
      logic              is_zero;
   } entry_type;

endpackage

`default_nettype wire

@@ rtl/core/luhn_if.sv @@
`default_nettype none

interface luhn_req_if;
   logic                          valid;
   logic                          ready;
   logic [luhn_pkg::CARD_W-1:0]   card_number;

   modport source (output valid, output card_number, input ready);
   modport sink   (input valid, input card_number, output ready);
endinterface

interface luhn_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          checksum_ok;
   logic [luhn_pkg::COUNT_W-1:0]  digit_count;
   logic [luhn_pkg::CLASS_W-1:0]  card_class;

   modport source (output valid, output checksum_ok, output digit_count,
                   output card_class, input ready);
   modport sink   (input valid, input checksum_ok, input digit_count,
                   input card_class, output ready);
endinterface

`default_nettype wire

@@ rtl/core/luhn_front.sv @@
`default_nettype none

// Accepts card numbers, flags zero, and holds them in a small queue.
module luhn_front #(
   parameter int QUEUE_DEPTH = luhn_pkg::QUEUE_DEPTH
) (
   input  wire                 clock,
   input  wire                 reset,
   luhn_req_if.sink            req,
   output logic                q_valid,
   output luhn_pkg::entry_type q_entry,
   input  wire                 q_ready
);

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   luhn_pkg::entry_type queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                push, pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign req.ready = (fill_ff != FILL_W'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (fill_ff != '0);
   assign pop       = q_valid && q_ready;
   assign q_entry   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff].card_number <= req.card_number;
         queue_ff[wr_ptr_ff].is_zero     <= (req.card_number == '0);
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("queue fill beyond its depth");

   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (fill_ff == $past(fill_ff) + FILL_W'(1)))
      else $error("queue fill did not follow a lone write");

endmodule

`default_nettype wire

@@ rtl/core/luhn_back.sv @@
`default_nettype none

// Converts one queued number to decimal, scans its digits and registers the result.
module luhn_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      q_valid,
   input  wire luhn_pkg::entry_type q_entry,
   output logic                     q_ready,
   luhn_rsp_if.source               rsp
);

   localparam int BCD_W   = luhn_pkg::BCD_W;
   localparam int BIN_W   = luhn_pkg::BIN_W;
   localparam int DIGITS  = luhn_pkg::DIGITS;
   localparam int STEP_W  = $clog2(luhn_pkg::CONV_STEPS);
   localparam int COUNT_W = luhn_pkg::COUNT_W;
   localparam int CLASS_W = luhn_pkg::CLASS_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SCAN
   } state_type;

   state_type            state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [BIN_W-1:0]     bin_ff, bin_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic                 par_ff, par_in;
   logic [3:0]           sum_ff, sum_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [3:0]           msd_ff, msd_in;
   logic [3:0]           nxt_ff, nxt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [CLASS_W-1:0]   rsp_class_ff, rsp_class_in;

   logic [BCD_W+BIN_W-1:0] dabbled;
   logic [3:0]             digit;
   logic [4:0]             digit_val;
   logic [4:0]             sum_raw;
   logic                   out_free;
   logic [CLASS_W-1:0]     class_code;

   // Several double-dabble steps: add three to each digit of five or more, then shift.
   function automatic logic [BCD_W+BIN_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                                      input logic [BIN_W-1:0] bin);
      logic [BCD_W-1:0] b;
      logic [BIN_W-1:0] r;
      b = bcd;
      r = bin;
      for (int s = 0; s < luhn_pkg::BITS_PER_CYCLE; s++) begin
         for (int i = 0; i < DIGITS; i++) begin
            if (b[i*4 +: 4] >= luhn_pkg::DOUBLE_MIN) begin
               b[i*4 +: 4] = b[i*4 +: 4] + 4'd3;
            end
         end
         b = {b[BCD_W-2:0], r[BIN_W-1]};
         r = {r[BIN_W-2:0], 1'b0};
      end
      return {b, r};
   endfunction

   assign dabbled  = dabble(bcd_ff, bin_ff);
   assign digit    = bcd_ff[3:0];
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign q_ready  = (state_ff == ST_IDLE);

   // Every second digit is doubled, folding a double above nine to its digit sum.
   always_comb begin
      if (par_ff) begin
         digit_val = (digit >= luhn_pkg::DOUBLE_MIN)
                   ? ({digit, 1'b0} - luhn_pkg::DOUBLE_FOLD)
                   : {digit, 1'b0};
      end else begin
         digit_val = {1'b0, digit};
      end
      sum_raw = {1'b0, sum_ff} + digit_val;
   end

   always_comb begin
      class_code = luhn_pkg::CLASS_INVALID;
      if (sum_ff == '0) begin
         if (cnt_ff == luhn_pkg::AMEX_LEN && msd_ff == luhn_pkg::AMEX_LEAD &&
             (nxt_ff == luhn_pkg::AMEX_NEXT_LO || nxt_ff == luhn_pkg::AMEX_NEXT_HI)) begin
            class_code = luhn_pkg::CLASS_AMEX;
         end else if ((cnt_ff == luhn_pkg::VISA_LEN_SHORT ||
                        cnt_ff == luhn_pkg::VISA_LEN_LONG) &&
                       msd_ff == luhn_pkg::VISA_LEAD) begin
            class_code = luhn_pkg::CLASS_VISA;
         end else if (cnt_ff == luhn_pkg::MC_LEN && msd_ff == luhn_pkg::MC_LEAD &&
                      nxt_ff >= luhn_pkg::MC_NEXT_MIN &&
                      nxt_ff <= luhn_pkg::MC_NEXT_MAX) begin
            class_code = luhn_pkg::CLASS_MASTERCARD;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      par_in       = par_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      msd_in       = msd_ff;
      nxt_in       = nxt_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;
      rsp_class_in = rsp_class_ff;
      rsp_valid_in = rsp.ready ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               bin_in   = BIN_W'(q_entry.card_number);
               bcd_in   = '0;
               step_in  = '0;
               par_in   = 1'b0;
               sum_in   = '0;
               cnt_in   = '0;
               msd_in   = '0;
               nxt_in   = '0;
               state_in = q_entry.is_zero ? ST_SCAN : ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            bcd_in  = dabbled[BIN_W +: BCD_W];
            bin_in  = dabbled[BIN_W-1:0];
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(luhn_pkg::CONV_STEPS - 1)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (bcd_ff != '0) begin
               bcd_in = {4'd0, bcd_ff[BCD_W-1:4]};
               par_in = !par_ff;
               sum_in = (sum_raw >= luhn_pkg::DIGIT_BASE)
                      ? 4'(sum_raw - luhn_pkg::DIGIT_BASE)
                      : sum_raw[3:0];
               cnt_in = cnt_ff + COUNT_W'(1);
               nxt_in = msd_ff;
               msd_in = digit;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = (sum_ff == '0);
               rsp_count_in = cnt_ff;
               rsp_class_in = class_code;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         par_ff       <= 1'b0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         par_ff       <= par_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
      msd_ff       <= msd_in;
      nxt_ff       <= nxt_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
      rsp_class_ff <= rsp_class_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.checksum_ok = rsp_ok_ff;
   assign rsp.digit_count = rsp_count_ff;
   assign rsp.card_class  = rsp_class_ff;

   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CONVERT) |-> (step_ff == '0))
      else $error("conversion step counter left running outside conversion");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      sum_ff < 4'(luhn_pkg::DIGIT_BASE))
      else $error("running digit sum is not reduced modulo ten");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= COUNT_W'(DIGITS))
      else $error("digit count beyond nineteen");

   a_class_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_class_ff != luhn_pkg::CLASS_INVALID)
      |-> (rsp_ok_ff && rsp_count_ff >= luhn_pkg::VISA_LEN_SHORT))
      else $error("card class given without a passing checksum and length");

endmodule

`default_nettype wire

@@ rtl/core/luhn_card_validator.sv @@
`default_nettype none

// Channel   Direction  Payload                                 Transfer when
// req       in         card_number[62:0]                       req.valid && req.ready
// rsp       out        checksum_ok, digit_count[4:0],          rsp.valid && rsp.ready
//                      card_class[1:0]
//
// A card number passes from the queue through the decimal converter and then the digit
// scan to its result; zero skips conversion. The decimal converter takes four bits a cycle
// over 64 bits, and the digit scan reads one digit a cycle. One number is worked at a time.
// Reset is synchronous and clears the queue and all control state; there is no clearing pass.
// The queue takes up to QUEUE_DEPTH numbers while the back part is busy, and the result
// register holds a result until it is taken while the back part begins the next number.
module luhn_card_validator #(
   parameter int QUEUE_DEPTH = luhn_pkg::QUEUE_DEPTH
) (
   input  wire        clock,
   input  wire        reset,
   luhn_req_if.sink   req,
   luhn_rsp_if.source rsp
);

   // Queue handshake between the front and back parts.
   logic                q_valid;
   logic                q_ready;
   luhn_pkg::entry_type q_entry;

   // The front part takes each transfer, marks a zero number so that the back part can
   // skip the conversion, and queues it.
   luhn_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_ready (q_ready)
   );

   // The back part converts the number to decimal, walks its digits from the least
   // significant upward to form the Luhn sum, the digit count and the two leading digits,
   // and classifies the card into its result register.
   luhn_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_ready (q_ready),
      .rsp     (rsp)
   );

endmodule

`default_nettype wire
